/* sv/tcw_pkg.sv */
package tcw_pkg;

    // Cursor movement requests from the sequencer to the cursor unit.
    typedef logic [1:0] cur_op_t;

    localparam cur_op_t CUR_ADVANCE = 2'd0;
    localparam cur_op_t CUR_BACK    = 2'd1;
    localparam cur_op_t CUR_RETURN  = 2'd2;
    localparam cur_op_t CUR_NEWLINE = 2'd3;

    typedef struct packed {
        logic    valid;
        cur_op_t op;
    } cursor_cmd_t;

    typedef struct packed {
        logic scroll;
        logic tab_done;
    } cursor_stat_t;

    // Control bytes that the put path interprets, and the space used for blanks and tabs.
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Item kinds carried in s_tuser.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes and reset values.
    localparam logic       REG_TEXT_ATTR    = 1'b0;
    localparam logic       REG_BLANK_ATTR   = 1'b1;
    localparam logic [7:0] TEXT_ATTR_RESET  = 8'h0F;
    localparam logic [7:0] BLANK_ATTR_RESET = 8'h00;

endpackage

/* sv/tcw_cursor.sv */
module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cursor_cmd_t                cmd,
    output cursor_stat_t               stat,
    output logic [$clog2(COLUMNS)-1:0] col,
    output logic [$clog2(ROWS)-1:0]    row
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(TAB_STOP - 1);
    localparam logic [PH_W-1:0]  PH_WRAP  = PH_W'((COLUMNS - 1) % TAB_STOP);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    // Column modulo the tab stop, tracked alongside the column itself.
    logic [PH_W-1:0]  ph_reg, ph_next;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        ph_next  = ph_reg;
        stat     = '0;
        if (cmd.valid) begin
            unique case (cmd.op)
                CUR_ADVANCE: begin
                    if (col_reg == COL_LAST) begin
                        col_next = '0;
                        ph_next  = '0;
                        if (row_reg == ROW_LAST) begin
                            stat.scroll = 1'b1;
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end else begin
                        col_next = col_reg + COL_W'(1);
                        ph_next  = (ph_reg == PH_LAST) ? '0 : ph_reg + PH_W'(1);
                    end
                    stat.tab_done = (ph_next == '0);
                end
                CUR_BACK: begin
                    if (col_reg != '0) begin
                        col_next = col_reg - COL_W'(1);
                        ph_next  = (ph_reg == '0) ? PH_LAST : ph_reg - PH_W'(1);
                    end else begin
                        if (row_reg != '0) begin
                            row_next = row_reg - ROW_W'(1);
                        end
                        col_next = COL_LAST;
                        ph_next  = PH_WRAP;
                    end
                end
                CUR_RETURN: begin
                    col_next = '0;
                    ph_next  = '0;
                end
                CUR_NEWLINE: begin
                    col_next = '0;
                    ph_next  = '0;
                    if (row_reg == ROW_LAST) begin
                        stat.scroll = 1'b1;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ph_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            ph_reg  <= ph_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

endmodule

/* sv/text_console_writer_unit.sv */
// Text console writer: a ROWS x COLUMNS grid of 16-bit cells (character code in the low
// byte, attribute in the high byte) in a single memory, plus a cursor. Each input word is
// a put (s_tuser low) or a cell read (s_tuser high); each gives exactly one result word
// with the cell read (zero for puts) and the cursor after the item. Items are handled one
// at a time by a small sequencer around one memory write port and one registered read
// port. A read inside the grid passes from idle through a read state and a done state; a
// control byte or a printable byte passes through a put state and the done state; a read
// outside the grid goes straight to the done state. The result word is loaded in the done
// state once the output register is free, and the next word can then be taken. A tab
// passes through the put state once for each space it writes (up to TAB_STOP spaces).
// When the cursor moves past the last row the screen scrolls: the memory is copied up one
// row, each cell read and then written, and the bottom row is cleared to blanks at one
// cell per cycle. After reset the memory is swept to blanks, during which no input word
// is taken; register writes are taken at any time. A new item is accepted while the
// previous result word is still waiting on m_tready.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13], zero
    input  logic        s_tuser,  // op[0]
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // cell_char[7:0], cell_attr[15:8], cursor_col[22:16],
                                  // cursor_row[27:23], zero
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_READ    = 3'd2;
    localparam logic [2:0] ST_PUT     = 3'd3;
    localparam logic [2:0] ST_COPY_RD = 3'd4;
    localparam logic [2:0] ST_COPY_WR = 3'd5;
    localparam logic [2:0] ST_CLEAR   = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [7:0]        code_reg, code_next;
    logic              tab_more_reg, tab_more_next;
    logic [7:0]        res_char_reg, res_char_next;
    logic [7:0]        res_attr_reg, res_attr_next;
    logic [7:0]        text_attr_reg, blank_attr_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    logic [15:0]       mem [CELL_COUNT];
    logic [15:0]       rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    cursor_cmd_t       cur_cmd;
    cursor_stat_t      cur_stat;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;

    logic [7:0]        in_char;
    logic [4:0]        in_row;
    logic [6:0]        in_col;
    logic              in_range;
    logic [ADDR_W-1:0] read_addr, cursor_addr;
    logic              is_tab, tab_more;
    logic              cfg_write, out_load;

    assign in_char  = s_tdata[7:0];
    assign in_row   = s_tdata[12:8];
    assign in_col   = s_tdata[19:13];
    assign in_range = (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS);

    assign read_addr   = ADDR_W'(in_row) * ROW_SPAN + ADDR_W'(in_col);
    assign cursor_addr = ADDR_W'(cur_row) * ROW_SPAN + ADDR_W'(cur_col);

    assign is_tab   = (code_reg == CH_TAB);
    assign tab_more = is_tab && !cur_stat.tab_done;

    tcw_cursor #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cur_cmd),
        .stat    (cur_stat),
        .col     (cur_col),
        .row     (cur_row)
    );

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg  <= TEXT_ATTR_RESET;
            blank_attr_reg <= BLANK_ATTR_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_TEXT_ATTR:  text_attr_reg  <= pwdata[7:0];
                REG_BLANK_ATTR: blank_attr_reg <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TEXT_ATTR:  prdata = {24'd0, text_attr_reg};
            REG_BLANK_ATTR: prdata = {24'd0, blank_attr_reg};
            default:        prdata = '0;
        endcase
    end

    // Sequencer.
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        code_next     = code_reg;
        tab_more_next = tab_more_reg;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        mem_we        = 1'b0;
        mem_waddr     = scan_reg;
        mem_wdata     = {blank_attr_reg, CH_SPACE};
        mem_re        = 1'b0;
        mem_raddr     = read_addr;
        cur_cmd       = '0;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {BLANK_ATTR_RESET, CH_SPACE};
                if (scan_reg == CELL_LAST) begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    if (s_tuser == OP_READ) begin
                        if (in_range) begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        code_next  = in_char;
                        state_next = ST_PUT;
                    end
                end
            end
            ST_READ: begin
                res_char_next = rd_data_reg[7:0];
                res_attr_next = rd_data_reg[15:8];
                state_next    = ST_DONE;
            end
            ST_PUT: begin
                cur_cmd.valid = 1'b1;
                unique case (code_reg)
                    CH_BEL: begin
                        cur_cmd.valid = 1'b0;
                        state_next    = ST_DONE;
                    end
                    CH_BS: begin
                        cur_cmd.op = CUR_BACK;
                        state_next = ST_DONE;
                    end
                    CH_CR: begin
                        cur_cmd.op = CUR_RETURN;
                        state_next = ST_DONE;
                    end
                    CH_LF: begin
                        cur_cmd.op = CUR_NEWLINE;
                        if (cur_stat.scroll) begin
                            tab_more_next = 1'b0;
                            scan_next     = '0;
                            state_next    = ST_COPY_RD;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        // All other bytes, printable or not, and each space of a tab.
                        cur_cmd.op = CUR_ADVANCE;
                        mem_we     = 1'b1;
                        mem_waddr  = cursor_addr;
                        mem_wdata  = {text_attr_reg, is_tab ? CH_SPACE : code_reg};
                        if (cur_stat.scroll) begin
                            tab_more_next = tab_more;
                            scan_next     = '0;
                            state_next    = ST_COPY_RD;
                        end else if (!tab_more) begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_COPY_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = scan_reg + ROW_SPAN;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg;
                scan_next  = scan_reg + ADDR_W'(1);
                state_next = (scan_reg == COPY_LAST) ? ST_CLEAR : ST_COPY_RD;
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (scan_reg == CELL_LAST) begin
                    state_next = tab_more_reg ? ST_PUT : ST_DONE;
                end else begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            scan_reg     <= '0;
            tab_more_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            tab_more_reg <= tab_more_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
    end

    // Cell memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Output register; it frees the sequencer while a word waits on m_tready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'd0, 5'(cur_row), 7'(cur_col), res_attr_reg, res_char_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/tcw_checker.sv */
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Reset leaves no result pending and the block busy with its memory sweep.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or ready seen right after reset");

    // One item at a time: acceptance is followed by a busy cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed or dropped");

    // The reported cursor always lies on the grid.
    a_cursor_on_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[22:16]) < COLUMNS)
                     && ((ROWS > 32) || (int'(m_tdata[27:23]) < ROWS)))
        else $error("cursor outside the grid");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

/* sim/tcw_screen_monitor.sv */
module tcw_screen_monitor
    import tcw_pkg::*;
#(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          error_count,
    output int          results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = ROWS * COLS;

    typedef struct {
        logic [7:0] glyph;
        logic [7:0] attr;
        logic [6:0] col;
        logic [4:0] row;
    } cell_report_t;

    logic [15:0]  screen [CELLS];
    int           cur_col;
    int           cur_row;
    logic [7:0]   text_attr;
    logic [7:0]   blank_attr;
    cell_report_t expected_reports [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic scroll_up();
        int i;
        for (i = 0; i < CELLS - COLS; i++) begin
            screen[i] = screen[i + COLS];
        end
        for (i = CELLS - COLS; i < CELLS; i++) begin
            screen[i] = {blank_attr, CH_SPACE};
        end
        if (cur_row > 0) begin
            cur_row--;
        end
    endtask

    task automatic lay_glyph(input logic [7:0] code);
        if (cur_row < ROWS && cur_col < COLS) begin
            screen[cur_row * COLS + cur_col] = {text_attr, code};
        end
        cur_col++;
        if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) begin
            scroll_up();
        end
    endtask

    task automatic interpret_byte(input logic [7:0] code);
        case (code)
            CH_BEL: begin
            end
            CH_BS: begin
                // At the left edge the cursor wraps to the last column and
                // climbs a row unless it is already at the top.
                if (cur_col != 0) begin
                    cur_col--;
                end else begin
                    if (cur_row != 0) begin
                        cur_row--;
                    end
                    cur_col = COLS - 1;
                end
            end
            CH_CR: begin
                cur_col = 0;
            end
            CH_LF: begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= ROWS) begin
                    scroll_up();
                end
            end
            CH_TAB: begin
                do begin
                    lay_glyph(CH_SPACE);
                end while ((cur_col % TAB_STOP) != 0);
            end
            default: begin
                lay_glyph(code);
            end
        endcase
    endtask

    task automatic predict_item(input logic op, input logic [7:0] code, input logic [4:0] rrow,
                                input logic [6:0] rcol, output cell_report_t rep);
        logic [15:0] picked;
        picked = 16'h0000;
        if (op == OP_PUT) begin
            interpret_byte(code);
        end else if (rrow < ROWS && rcol < COLS) begin
            picked = screen[rrow * COLS + rcol];
        end
        rep.glyph = picked[7:0];
        rep.attr  = picked[15:8];
        rep.col   = 7'(cur_col);
        rep.row   = 5'(cur_row);
    endtask

    always @(posedge aclk) begin
        cell_report_t seen;
        cell_report_t want;
        int i;
        if (!aresetn) begin
            for (i = 0; i < CELLS; i++) begin
                screen[i] = {8'h00, CH_SPACE};
            end
            cur_col = 0;
            cur_row = 0;
            text_attr = TEXT_ATTR_RESET;
            blank_attr = BLANK_ATTR_RESET;
            expected_reports.delete();
        end else begin
            // Results are retired before new words are predicted, so a word
            // accepted on this edge never pairs with a result on the same edge.
            if (m_tvalid && m_tready) begin
                seen.glyph = m_tdata[7:0];
                seen.attr  = m_tdata[15:8];
                seen.col   = m_tdata[22:16];
                seen.row   = m_tdata[27:23];
                if (expected_reports.size() == 0) begin
                    report_mismatch("result word with none expected", m_tdata, 0);
                end else begin
                    want = expected_reports.pop_front();
                    if (seen.glyph !== want.glyph) begin
                        report_mismatch("cell_char", seen.glyph, want.glyph);
                    end
                    if (seen.attr !== want.attr) begin
                        report_mismatch("cell_attr", seen.attr, want.attr);
                    end
                    if (seen.col !== want.col) begin
                        report_mismatch("cursor_col", seen.col, want.col);
                    end
                    if (seen.row !== want.row) begin
                        report_mismatch("cursor_row", seen.row, want.row);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr >> 2)
                    3'(REG_TEXT_ATTR): begin
                        text_attr = pwdata[7:0];
                    end
                    3'(REG_BLANK_ATTR): begin
                        blank_attr = pwdata[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tdata[19:13], want);
                expected_reports.push_back(want);
            end
        end
        results_pending <= expected_reports.size();
    end

endmodule

/* sim/tb_text_console_writer_unit.sv */
module tb_text_console_writer_unit;
    import tcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CON_COLS     = 80;
    localparam int CON_ROWS     = 25;
    localparam int CON_TAB      = 4;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 108;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam int DRAIN_CYCLES = 50;
    // Worst case per word: both idle draws, a tab and a full scroll copy.
    localparam int CYCLE_LIMIT  = 12_000_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    int error_count;
    int results_pending;
    int items_sent = 0;
    int cycle_count = 0;
    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;
    bit hold_request = 1'b0;

    always #5 aclk = ~aclk;

    text_console_writer_unit #(
        .COLUMNS  (CON_COLS),
        .ROWS     (CON_ROWS),
        .TAB_STOP (CON_TAB)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tcw_screen_monitor #(
        .COLS     (CON_COLS),
        .ROWS     (CON_ROWS),
        .TAB_STOP (CON_TAB)
    ) i_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    function automatic int pick_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic send_item(input logic op, input logic [7:0] code, input int rrow,
                             input int rcol);
        int gap;
        gap = pick_wait(sender_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = op;
        s_tdata = {4'h0, 7'(rcol), 5'(rrow), code};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // The read fields of a put are don't-care, so they carry random bits.
    task automatic put_byte(input logic [7:0] code);
        send_item(OP_PUT, code, $urandom_range(0, 31), $urandom_range(0, 127));
    endtask

    task automatic read_cell(input int rrow, input int rcol);
        send_item(OP_READ, 8'($urandom_range(0, 255)), rrow, rcol);
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // The pending count is registered, so look only after at least one edge.
    task automatic wait_drained();
        do @(posedge aclk); while (results_pending != 0);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = {24'h0, value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            // A long hold-off lets the block fill up and stall its input.
            if (hold_request) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            stall = pick_wait(receiver_calm);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if ($urandom_range(0, 40) == 0) begin
                receiver_calm = !receiver_calm;
            end
        end
    end

    initial begin
        int phase;
        int quota;
        int burst_len;
        int k;
        int kind;
        bit paused;
        logic [7:0] text_value;
        logic [7:0] blank_value;

        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_PUT;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words under the reset attributes: reads of the blank
        // screen, reads outside the grid, and every control byte at its edges.
        read_cell(0, 0);
        read_cell(CON_ROWS - 1, CON_COLS - 1);
        read_cell(31, 127);
        read_cell(CON_ROWS, 0);
        read_cell(0, CON_COLS);
        put_byte(CH_BS);
        put_byte(CH_TAB);
        read_cell(0, CON_COLS - 1);
        put_byte("A");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_BEL);
        put_byte(CH_BS);
        put_byte(CH_TAB);
        put_byte(CH_CR);
        put_byte(CH_BS);
        put_byte(CH_LF);
        read_cell(1, 0);
        read_cell(1, 2);
        put_byte(8'h7F);
        read_cell(1, 1);

        for (phase = 0; phase < PHASES; phase++) begin
            release_input();
            wait_drained();
            repeat (SETTLE) @(posedge aclk);
            case (phase)
                0: begin
                    text_value = 8'hFF;
                    blank_value = 8'h00;
                end
                1: begin
                    text_value = 8'h00;
                    blank_value = 8'hFF;
                end
                2: begin
                    text_value = 8'hA5;
                    blank_value = 8'h5A;
                end
                5: begin
                    text_value = TEXT_ATTR_RESET;
                    blank_value = BLANK_ATTR_RESET;
                end
                default: begin
                    text_value = 8'($urandom_range(0, 255));
                    blank_value = 8'($urandom_range(0, 255));
                end
            endcase
            write_register({REG_TEXT_ATTR, 2'b00}, text_value);
            write_register({REG_BLANK_ATTR, 2'b00}, blank_value);
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            paused = 1'b0;
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota) begin
                if ($urandom_range(0, 19) == 0) begin
                    sender_calm = !sender_calm;
                end
                if (phase == 1 && !paused && items_sent >= quota - PHASE_ITEMS / 2) begin
                    release_input();
                    wait_drained();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    burst_len = $urandom_range(1, 12);
                    for (k = 0; k < burst_len; k++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            put_byte(8'($urandom_range(8'h80, 8'hFF)));
                        end else begin
                            put_byte(8'($urandom_range(8'h20, 8'h7E)));
                        end
                    end
                end else if (kind < 55) begin
                    if ($urandom_range(0, 1) == 1) begin
                        put_byte(CH_CR);
                    end
                    put_byte(CH_LF);
                end else if (kind < 62) begin
                    burst_len = $urandom_range(1, 6);
                    for (k = 0; k < burst_len; k++) begin
                        put_byte(CH_LF);
                    end
                end else if (kind < 70) begin
                    burst_len = $urandom_range(1, 3);
                    for (k = 0; k < burst_len; k++) begin
                        put_byte(CH_TAB);
                    end
                end else if (kind < 77) begin
                    if ($urandom_range(0, 1) == 1) begin
                        put_byte(CH_CR);
                    end
                    burst_len = $urandom_range(1, 5);
                    for (k = 0; k < burst_len; k++) begin
                        put_byte(CH_BS);
                    end
                end else if (kind < 90) begin
                    // Most text lands near the bottom once scrolling starts.
                    burst_len = $urandom_range(1, 4);
                    for (k = 0; k < burst_len; k++) begin
                        if ($urandom_range(0, 1) == 1) begin
                            read_cell(CON_ROWS - 1 - $urandom_range(0, 2),
                                      $urandom_range(0, CON_COLS - 1));
                        end else begin
                            read_cell($urandom_range(0, CON_ROWS - 1),
                                      $urandom_range(0, CON_COLS - 1));
                        end
                    end
                end else begin
                    burst_len = $urandom_range(1, 4);
                    for (k = 0; k < burst_len; k++) begin
                        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 31), $urandom_range(0, 127));
                    end
                end
            end
        end

        release_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
